// ===== rtl/gdd_pkg.sv =====
package gdd_pkg;

  // Width of the day count on the result channel.
  localparam int unsigned COUNT_W = 23;

  // Stages inside each date lane; the compare stage follows them.
  localparam int unsigned LANE_STAGES = 4;

  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned DAYS_PER_YEAR   = 365;
  localparam int unsigned YEARS_PER_CENT  = 100;
  localparam int unsigned QUARTER_CENT    = 25;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FIRST_BAD  = 2'd1,
    ST_SECOND_BAD = 2'd2,
    ST_EARLIER    = 2'd3
  } status_e;

  // Days before the first of a month in a common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/gdd_if.sv =====
interface gdd_in_if #(
  parameter int unsigned YEAR_BITS = 14
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           first_day;
  logic [3:0]           first_month;
  logic [YEAR_BITS-1:0] first_year;
  logic [4:0]           second_day;
  logic [3:0]           second_month;
  logic [YEAR_BITS-1:0] second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

interface gdd_out_if;
  logic                             valid;
  logic                             ready;
  gdd_pkg::status_e                 status;
  logic [gdd_pkg::COUNT_W-1:0]      day_count;

  modport source (output valid, status, day_count, input ready);
  modport sink (input valid, status, day_count, output ready);
endinterface

// ===== rtl/gregorian_date_difference_top.sv =====
// Gregorian date difference. Each input beat carries two proleptic Gregorian dates; each
// output beat carries a status (ok, first date invalid, second date invalid, second date
// earlier) and the number of days from the first date to the second, zero unless the
// status is ok. One date pair is taken every clock cycle while the output is not stalled.
// Four stages in each date lane build a day number (the divide by 25 behind the century
// count needs a multiply stage and a correction stage), and a fifth stage compares and
// subtracts. Each stage holds its item while the stage after it is full, so bubbles are
// squeezed out during a stall and the input keeps accepting until every stage is occupied.
module gregorian_date_difference_top #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdd_in_if.sink    in_i,
  gdd_out_if.source out_o
);

  localparam int unsigned NS  = gdd_pkg::LANE_STAGES;
  localparam int unsigned DNW = YEAR_BITS + 9;

  logic [NS:0]    en;
  logic [NS-1:0]  vld_q;
  logic           out_vld_q;

  logic [DNW-1:0] first_num, second_num;
  logic           first_ok, second_ok;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    en[NS] = !out_vld_q || out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (en[NS]) begin
        out_vld_q <= vld_q[NS-1];
      end
    end
  end

  gdd_date_lane #(.YEAR_BITS(YEAR_BITS)) u_first_lane (
    .clk_i     (clk_i),
    .en_i      (en[NS-1:0]),
    .day_i     (in_i.first_day),
    .month_i   (in_i.first_month),
    .year_i    (in_i.first_year),
    .day_num_o (first_num),
    .date_ok_o (first_ok)
  );

  gdd_date_lane #(.YEAR_BITS(YEAR_BITS)) u_second_lane (
    .clk_i     (clk_i),
    .en_i      (en[NS-1:0]),
    .day_i     (in_i.second_day),
    .month_i   (in_i.second_month),
    .year_i    (in_i.second_year),
    .day_num_o (second_num),
    .date_ok_o (second_ok)
  );

  gdd_compare #(.YEAR_BITS(YEAR_BITS)) u_compare (
    .clk_i        (clk_i),
    .en_i         (en[NS]),
    .first_ok_i   (first_ok),
    .second_ok_i  (second_ok),
    .first_num_i  (first_num),
    .second_num_i (second_num),
    .status_o     (out_o.status),
    .day_count_o  (out_o.day_count)
  );

  assign out_o.valid = out_vld_q;

endmodule

// ===== rtl/gdd_date_lane.sv =====
module gdd_date_lane #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic                                clk_i,
  input  logic [gdd_pkg::LANE_STAGES-1:0]     en_i,
  input  logic [4:0]                          day_i,
  input  logic [3:0]                          month_i,
  input  logic [YEAR_BITS-1:0]                year_i,
  output logic [YEAR_BITS+8:0]                day_num_o,
  output logic                                date_ok_o
);

  localparam int unsigned AW  = YEAR_BITS - 2;
  localparam int unsigned DNW = YEAR_BITS + 9;
  localparam int unsigned PW  = 2 * AW;
  // Reciprocal of 25 scaled by 2**AW, rounded down; the estimate is low by at most one.
  localparam logic [AW-1:0] RECIP = AW'((2 ** AW) / gdd_pkg::QUARTER_CENT);

  // Stage 1: elapsed years, quarter count and the reciprocal product.
  logic [YEAR_BITS-1:0] p_s;
  logic [AW-1:0]        a_s;
  logic                 ok_s;
  logic [4:0]           s1_day_q;
  logic [3:0]           s1_month_q;
  logic [YEAR_BITS-1:0] s1_p_q;
  logic [AW-1:0]        s1_a_q;
  logic [PW-1:0]        s1_prod_q, s1_prod_d;
  logic                 s1_ok_q;

  assign p_s  = year_i - YEAR_BITS'(1);
  assign a_s  = p_s[YEAR_BITS-1:2];
  assign ok_s = (month_i != 4'd0) && (month_i <= 4'(gdd_pkg::MONTHS_PER_YEAR)) &&
                (year_i != '0) && (day_i != 5'd0);
  assign s1_prod_d = PW'(a_s) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_day_q   <= day_i;
      s1_month_q <= month_i;
      s1_p_q     <= p_s;
      s1_a_q     <= a_s;
      s1_prod_q  <= s1_prod_d;
      s1_ok_q    <= ok_s;
    end
  end

  // Stage 2: correct the quotient estimate to give whole centuries elapsed.
  logic [AW-1:0]        q_est;
  logic [AW-1:0]        rem;
  logic [AW-1:0]        s2_c_d, s2_c_q;
  logic [4:0]           s2_day_q;
  logic [3:0]           s2_month_q;
  logic [YEAR_BITS-1:0] s2_p_q;
  logic [AW-1:0]        s2_a_q;
  logic                 s2_ok_q;

  assign q_est  = s1_prod_q[PW-1:AW];
  assign rem    = s1_a_q - AW'(q_est * AW'(gdd_pkg::QUARTER_CENT));
  assign s2_c_d = q_est + AW'(rem >= AW'(gdd_pkg::QUARTER_CENT));

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_day_q   <= s1_day_q;
      s2_month_q <= s1_month_q;
      s2_p_q     <= s1_p_q;
      s2_a_q     <= s1_a_q;
      s2_c_q     <= s2_c_d;
      s2_ok_q    <= s1_ok_q;
    end
  end

  // Stage 3: leap test, day range check and the bulk of the day number.
  // The year itself is p + 1, so its divisibility shows as remainders of p at the top.
  logic [YEAR_BITS-1:0] p_mod_cent;
  logic                 leap_s;
  logic [DNW-1:0]       s3_base_d, s3_base_q;
  logic                 s3_leap_q;
  logic                 s3_ok_q;
  logic [AW-1:0]        s3_c_q;
  logic [4:0]           s3_day_q;
  logic [3:0]           s3_month_q;

  assign p_mod_cent = s2_p_q - YEAR_BITS'(YEAR_BITS'(s2_c_q) *
                                          YEAR_BITS'(gdd_pkg::YEARS_PER_CENT));
  assign leap_s = (s2_p_q[1:0] == 2'b11) &&
                  ((p_mod_cent != YEAR_BITS'(gdd_pkg::YEARS_PER_CENT - 1)) ||
                   (s2_c_q[1:0] == 2'b11));
  assign s3_base_d = DNW'(DNW'(s2_p_q) * DNW'(gdd_pkg::DAYS_PER_YEAR)) + DNW'(s2_a_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_base_q  <= s3_base_d;
      s3_leap_q  <= leap_s;
      s3_ok_q    <= s2_ok_q && (s2_day_q <= gdd_pkg::month_length(s2_month_q, leap_s));
      s3_c_q     <= s2_c_q;
      s3_day_q   <= s2_day_q;
      s3_month_q <= s2_month_q;
    end
  end

  // Stage 4: century corrections, month offset and day of month.
  logic [DNW-1:0] s4_dn_d, s4_dn_q;
  logic           s4_ok_q;

  assign s4_dn_d = s3_base_q - DNW'(s3_c_q) + DNW'(s3_c_q >> 2) +
                   DNW'(gdd_pkg::days_before_month(s3_month_q)) +
                   DNW'(s3_leap_q && (s3_month_q > 4'd2)) + DNW'(s3_day_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_dn_q <= s4_dn_d;
      s4_ok_q <= s3_ok_q;
    end
  end

  assign day_num_o = s4_dn_q;
  assign date_ok_o = s4_ok_q;

endmodule

// ===== rtl/gdd_compare.sv =====
module gdd_compare #(
  parameter int unsigned YEAR_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          first_ok_i,
  input  logic                          second_ok_i,
  input  logic [YEAR_BITS+8:0]          first_num_i,
  input  logic [YEAR_BITS+8:0]          second_num_i,
  output gdd_pkg::status_e              status_o,
  output logic [gdd_pkg::COUNT_W-1:0]   day_count_o
);

  localparam int unsigned DNW = YEAR_BITS + 9;

  logic [DNW:0]                  diff;
  gdd_pkg::status_e              status_d, status_q;
  logic [gdd_pkg::COUNT_W-1:0]   count_d, count_q;

  // The extra top bit is the borrow: set when the second date comes first.
  assign diff = {1'b0, second_num_i} - {1'b0, first_num_i};

  always_comb begin
    count_d = '0;
    if (!first_ok_i) begin
      status_d = gdd_pkg::ST_FIRST_BAD;
    end else if (!second_ok_i) begin
      status_d = gdd_pkg::ST_SECOND_BAD;
    end else if (diff[DNW]) begin
      status_d = gdd_pkg::ST_EARLIER;
    end else begin
      status_d = gdd_pkg::ST_OK;
      count_d  = gdd_pkg::COUNT_W'(diff[DNW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign status_o    = status_q;
  assign day_count_o = count_q;

endmodule

// ===== rtl/gdd_checker.sv =====
module gdd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input gdd_pkg::status_e              out_status_i,
  input logic [gdd_pkg::COUNT_W-1:0]   out_day_count_i
);

  // Only an ok result carries a day count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i != gdd_pkg::ST_OK)) |-> (out_day_count_i == '0))
    else $error("day count non-zero on a result that is not ok");

  // A result beat that is not taken holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_status_i) && $stable(out_day_count_i)))
    else $error("stalled result beat changed");

  // With the output side empty nothing can block the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while the output is empty");

  // Without back-pressure an input beat comes out after passing the lane stages and the compare stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && out_ready_i) ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after an unstalled pass");

endmodule

bind gregorian_date_difference_top gdd_checker u_gdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_day_count_i (out_o.day_count)
);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned YEAR_BITS = 14;
  localparam int unsigned YEAR_MAX  = (1 << YEAR_BITS) - 1;

  typedef struct packed {
    logic [4:0]           first_day;
    logic [3:0]           first_month;
    logic [YEAR_BITS-1:0] first_year;
    logic [4:0]           second_day;
    logic [3:0]           second_month;
    logic [YEAR_BITS-1:0] second_year;
  } date_pair_t;

  typedef struct packed {
    gdd_pkg::status_e              status;
    logic [gdd_pkg::COUNT_W-1:0]   count;
  } day_gap_t;

  // Keeps the day gaps still owed by the block, oldest first, and checks each result beat.
  class date_gap_board;
    day_gap_t    owed_gaps[$];
    int unsigned faults;
    int unsigned seen[4];

    static function bit leap(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_days(int unsigned m, int unsigned y);
      if (m == 2) return leap(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    static function bit date_ok(int unsigned d, int unsigned m, int unsigned y);
      return (m >= 1) && (m <= 12) && (y >= 1) && (d >= 1) && (d <= month_days(m, y));
    endfunction

    // Days since the start of the calendar; the first of January of year 1 gives 1.
    static function longint unsigned day_index(int unsigned d, int unsigned m,
                                               int unsigned y);
      longint unsigned past;
      longint unsigned n;
      past = y - 1;
      n = 365 * past + past / 4 - past / 100 + past / 400;
      for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
      return n + d;
    endfunction

    static function day_gap_t predict(date_pair_t p);
      day_gap_t        g;
      longint unsigned n1;
      longint unsigned n2;
      g.count = '0;
      if (!date_ok(p.first_day, p.first_month, p.first_year)) begin
        g.status = gdd_pkg::ST_FIRST_BAD;
      end else if (!date_ok(p.second_day, p.second_month, p.second_year)) begin
        g.status = gdd_pkg::ST_SECOND_BAD;
      end else begin
        n1 = day_index(p.first_day, p.first_month, p.first_year);
        n2 = day_index(p.second_day, p.second_month, p.second_year);
        if (n2 < n1) begin
          g.status = gdd_pkg::ST_EARLIER;
        end else begin
          g.status = gdd_pkg::ST_OK;
          g.count  = gdd_pkg::COUNT_W'(n2 - n1);
        end
      end
      return g;
    endfunction

    function void note_pair(date_pair_t p);
      owed_gaps.push_back(predict(p));
    endfunction

    function void check_gap(gdd_pkg::status_e st, logic [gdd_pkg::COUNT_W-1:0] cnt);
      day_gap_t want;
      if (owed_gaps.size() == 0) begin
        $display("%0t: result beat with nothing owed, status %0d count %0d", $time, st, cnt);
        faults++;
        return;
      end
      want = owed_gaps.pop_front();
      seen[want.status]++;
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, st);
        faults++;
      end
      if (cnt !== want.count) begin
        $display("%0t: day count mismatch, expected %0d, got %0d", $time, want.count, cnt);
        faults++;
      end
    endfunction

    function int unsigned pending();
      return owed_gaps.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;

  date_gap_board board = new;

  gdd_in_if #(.YEAR_BITS(YEAR_BITS)) in_bus ();
  gdd_out_if                         out_bus ();

  gregorian_date_difference_top #(.YEAR_BITS(YEAR_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one; none at all while calm.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic date_pair_t pair_of(int unsigned d1, int unsigned m1, int unsigned y1,
                                         int unsigned d2, int unsigned m2, int unsigned y2);
    date_pair_t p;
    p.first_day    = 5'(d1);
    p.first_month  = 4'(m1);
    p.first_year   = YEAR_BITS'(y1);
    p.second_day   = 5'(d2);
    p.second_month = 4'(m2);
    p.second_year  = YEAR_BITS'(y2);
    return p;
  endfunction

  function automatic int unsigned pick_year();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, YEAR_MAX);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 75) return $urandom_range(YEAR_MAX - 2, YEAR_MAX);
    if (r < 88) return $urandom_range(1, YEAR_MAX / 100) * 100;
    return $urandom_range(1, YEAR_MAX / 4) * 4;
  endfunction

  function automatic void good_date(output int unsigned d, output int unsigned m,
                                    output int unsigned y);
    int unsigned len;
    y   = pick_year();
    m   = $urandom_range(1, 12);
    len = date_gap_board::month_days(m, y);
    d   = ($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len);
  endfunction

  function automatic void bad_date(output int unsigned d, output int unsigned m,
                                   output int unsigned y);
    int unsigned c;
    good_date(d, m, y);
    case ($urandom_range(0, 5))
      0: m = 0;
      1: m = $urandom_range(13, 15);
      2: y = 0;
      3: d = 0;
      4: begin
        case ($urandom_range(0, 4))
          0: m = 2;
          1: m = 4;
          2: m = 6;
          3: m = 9;
          default: m = 11;
        endcase
        d = $urandom_range(date_gap_board::month_days(m, y) + 1, 31);
      end
      default: begin
        // February 29 in a common year, century years among them.
        m = 2;
        d = 29;
        if ($urandom_range(0, 1) == 0) begin
          c = $urandom_range(1, YEAR_MAX / 100);
          if (c % 4 == 0) c = c - 1;
          y = c * 100;
        end else begin
          y = $urandom_range(1, YEAR_MAX);
          if (date_gap_board::leap(y)) y = y ^ 1;
        end
      end
    endcase
  endfunction

  function automatic date_pair_t random_pair();
    int unsigned d1, m1, y1, d2, m2, y2;
    int unsigned pick;
    logic [63:0] rnd;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      good_date(d1, m1, y1);
      good_date(d2, m2, y2);
      // Keep most pairs in order so that the count path sees most of the traffic.
      if ($urandom_range(0, 9) < 7 &&
          date_gap_board::day_index(d2, m2, y2) < date_gap_board::day_index(d1, m1, y1))
        return pair_of(d2, m2, y2, d1, m1, y1);
    end else if (pick < 58) begin
      good_date(d1, m1, y1);
      d2 = d1;
      m2 = m1;
      y2 = y1;
    end else if (pick < 68) begin
      good_date(d1, m1, y1);
      y2 = y1 + (($urandom_range(0, 1) == 0 || y1 == YEAR_MAX) ? 0 : 1);
      m2 = $urandom_range(1, 12);
      d2 = $urandom_range(1, date_gap_board::month_days(m2, y2));
    end else if (pick < 78) begin
      bad_date(d1, m1, y1);
      if ($urandom_range(0, 1) == 0) good_date(d2, m2, y2);
      else bad_date(d2, m2, y2);
    end else if (pick < 88) begin
      good_date(d1, m1, y1);
      bad_date(d2, m2, y2);
    end else begin
      rnd = {$urandom, $urandom};
      return date_pair_t'(rnd[$bits(date_pair_t)-1:0]);
    end
    return pair_of(d1, m1, y1, d2, m2, y2);
  endfunction

  task automatic send_pair(input date_pair_t p);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.first_day    <= p.first_day;
    in_bus.first_month  <= p.first_month;
    in_bus.first_year   <= p.first_year;
    in_bus.second_day   <= p.second_day;
    in_bus.second_month <= p.second_month;
    in_bus.second_year  <= p.second_year;
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_pair(p);
  endtask

  // Holds the sender back until every owed result beat has come in.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        board.check_gap(out_bus.status, out_bus.day_count);
      if (hold != 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    in_bus.valid        <= 1'b0;
    in_bus.first_day    <= '0;
    in_bus.first_month  <= '0;
    in_bus.first_year   <= '0;
    in_bus.second_day   <= '0;
    in_bus.second_month <= '0;
    in_bus.second_year  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(pair_of(1, 1, 2000, 1, 1, 2000));
    send_pair(pair_of(1, 1, 1, 31, 12, YEAR_MAX));
    send_pair(pair_of(31, 12, YEAR_MAX, 1, 1, 1));
    send_pair(pair_of(31, 12, 1999, 1, 1, 2000));
    send_pair(pair_of(28, 2, 2000, 1, 3, 2000));
    send_pair(pair_of(28, 2, 1900, 1, 3, 1900));
    send_pair(pair_of(29, 2, 2024, 29, 2, 2028));
    send_pair(pair_of(29, 2, 1900, 1, 1, 2000));
    send_pair(pair_of(1, 1, 2000, 29, 2, 2100));
    send_pair(pair_of(0, 0, 0, 0, 0, 0));
    send_pair(pair_of(31, 15, YEAR_MAX, 31, 15, YEAR_MAX));
    send_pair(pair_of(1, 13, 2000, 1, 1, 2001));
    send_pair(pair_of(1, 1, 0, 1, 1, 1));
    send_pair(pair_of(0, 5, 2000, 1, 6, 2000));
    send_pair(pair_of(31, 4, 2000, 1, 5, 2000));
    send_pair(pair_of(1, 1, 2000, 1, 0, 2000));
    send_pair(pair_of(1, 1, 2000, 1, 14, 2000));
    send_pair(pair_of(1, 1, 2000, 1, 1, 0));
    send_pair(pair_of(1, 1, 2000, 31, 6, 2000));
    send_pair(pair_of(31, 1, 2000, 30, 1, 2000));
    send_pair(pair_of(15, 6, 2023, 15, 6, 2024));
    send_pair(pair_of(1, 3, 2000, 29, 2, 2000));
    drain();

    for (n = 0; n < 850; n++) begin
      calm = (n % 200) >= 150;
      if (n == 425) drain();
      send_pair(random_pair());
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("Checked %0d date pairs: %0d in order, %0d reversed,",
             board.seen[gdd_pkg::ST_OK] + board.seen[gdd_pkg::ST_FIRST_BAD]
             + board.seen[gdd_pkg::ST_SECOND_BAD] + board.seen[gdd_pkg::ST_EARLIER],
             board.seen[gdd_pkg::ST_OK], board.seen[gdd_pkg::ST_EARLIER]);
    $display("%0d with a bad first date and %0d with a bad second date; %0d faults.",
             board.seen[gdd_pkg::ST_FIRST_BAD], board.seen[gdd_pkg::ST_SECOND_BAD],
             board.faults);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Timed out with %0d result beats still owed.", board.pending());
    $display("testbench: FAIL");
    $finish;
  end

endmodule
